### src/toy_register_machine_execute_assert.svh
// ---------------------------------------------------------------------------
// toy register machine assertion macros
// shared property forms for the execute block checks
// ---------------------------------------------------------------------------
`ifndef TOY_REGISTER_MACHINE_EXECUTE_ASSERT_SVH
`define TOY_REGISTER_MACHINE_EXECUTE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define TRM_ASSERT_IMPL(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
    else $error("trm assertion failed");

// next-cycle implication, checked out of reset
`define TRM_ASSERT_NEXT(label, cond, expr) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
    else $error("trm assertion failed");

`endif

### src/trm_pkg.sv
// ---------------------------------------------------------------------------
// trm_pkg
// types, opcodes and handshake structs of the toy register machine execute
// ---------------------------------------------------------------------------
package trm_pkg;

  localparam int DATA_W = 32;
  localparam int ADDR_W = 10;
  localparam int WIDX_W = 5;
  localparam int CMD_W  = 5;

  // opcodes
  localparam logic [CMD_W-1:0] OP_MOV   = 5'd0;
  localparam logic [CMD_W-1:0] OP_ADD   = 5'd3;
  localparam logic [CMD_W-1:0] OP_SUB   = 5'd4;
  localparam logic [CMD_W-1:0] OP_MUL   = 5'd5;
  localparam logic [CMD_W-1:0] OP_DIV   = 5'd6;
  localparam logic [CMD_W-1:0] OP_REM   = 5'd7;
  localparam logic [CMD_W-1:0] OP_JUMP  = 5'd9;
  localparam logic [CMD_W-1:0] OP_JUMPN = 5'd10;
  localparam logic [CMD_W-1:0] OP_JUMPP = 5'd11;
  localparam logic [CMD_W-1:0] OP_JUMPZ = 5'd12;
  localparam logic [CMD_W-1:0] OP_SYS   = 5'd16;
  localparam logic [CMD_W-1:0] OP_EXIT  = 5'd18;

  // system service numbers
  localparam logic [DATA_W-1:0] SYS_READ  = 32'd1;
  localparam logic [DATA_W-1:0] SYS_PRINT = 32'd2;

  // configuration register index
  localparam logic REG_LAST_ADDRESS = 1'b0;

  typedef struct packed {
    logic [CMD_W-1:0]         command;
    logic [ADDR_W-1:0]        dest;
    logic                     first_is_register;
    logic signed [DATA_W-1:0] first_operand;
    logic                     second_is_register;
    logic signed [DATA_W-1:0] second_operand;
    logic signed [DATA_W-1:0] read_value;
  } item_t;

  typedef struct packed {
    logic [ADDR_W-1:0]        next_address;
    logic                     halted;
    logic                     write_valid;
    logic [WIDX_W-1:0]        write_index;
    logic signed [DATA_W-1:0] write_value;
    logic                     print_valid;
    logic signed [DATA_W-1:0] print_value;
    logic                     divide_error;
  } result_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIVIDE,
    ST_WRAP
  } state_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic start_div;
    logic commit;
  } ctl_t;

  // datapath to controller
  typedef struct packed {
    logic div_needed;
    logic div_done;
    logic div_busy;
    logic out_free;
  } sts_t;

endpackage

### src/trm_div.sv
// ---------------------------------------------------------------------------
// trm_div
// unsigned restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module trm_div (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic [trm_pkg::DATA_W-1:0] dividend,
  input  logic [trm_pkg::DATA_W-1:0] divisor,
  output logic                      busy,
  output logic                      done,
  output logic [trm_pkg::DATA_W-1:0] quotient,
  output logic [trm_pkg::DATA_W-1:0] remainder
);
  import trm_pkg::*;

  localparam int CNT_W = $clog2(DATA_W + 1);

  logic [DATA_W-1:0] quo;
  logic [DATA_W-1:0] rem;
  logic [DATA_W-1:0] dvs;
  logic [CNT_W-1:0]  cnt;
  logic [DATA_W:0]   shifted;
  logic [DATA_W:0]   diff;

  always_comb begin
    shifted = {rem, quo[DATA_W-1]};
    diff    = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNT_W'(DATA_W);
      end else if (busy) begin
        cnt <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= dividend;
      rem <= '0;
      dvs <= divisor;
    end else if (busy) begin
      // keep the partial remainder when the trial subtract goes negative
      if (!diff[DATA_W]) begin
        rem <= diff[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b1};
      end else begin
        rem <= shifted[DATA_W-1:0];
        quo <= {quo[DATA_W-2:0], 1'b0};
      end
    end
  end

  assign quotient  = quo;
  assign remainder = rem;

endmodule

### src/trm_ctrl.sv
// ---------------------------------------------------------------------------
// trm_ctrl
// sequencer: load, execute, wait on divide, commit
// ---------------------------------------------------------------------------
module trm_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          item_valid,
  output logic          item_ready,
  input  trm_pkg::sts_t sts,
  output trm_pkg::ctl_t ctl
);
  import trm_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    item_ready = 1'b0;
    ctl        = '0;
    case (state)
      ST_IDLE: begin
        item_ready = 1'b1;
        if (item_valid) begin
          ctl.load   = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.div_needed) begin
          ctl.start_div = 1'b1;
          state_next    = ST_DIVIDE;
        end else if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      ST_DIVIDE: begin
        if (sts.div_done) begin
          state_next = ST_WRAP;
        end
      end
      ST_WRAP: begin
        if (sts.out_free) begin
          ctl.commit = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

### src/trm_dp.sv
// ---------------------------------------------------------------------------
// trm_dp
// register file, operand fetch, alu, program counter and result register
// ---------------------------------------------------------------------------
module trm_dp #(
  parameter int NUM_REGISTERS = 26,
  parameter int PROGRAM_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  trm_pkg::item_t             item,
  input  trm_pkg::ctl_t              ctl,
  output trm_pkg::sts_t              sts,
  input  logic [trm_pkg::ADDR_W-1:0] last_address,
  output trm_pkg::result_t           result,
  output logic                       result_valid,
  input  logic                       result_ready
);
  import trm_pkg::*;

  localparam int RW = (NUM_REGISTERS > 1) ? $clog2(NUM_REGISTERS) : 1;

  // register file, entries not yet written read as zero
  logic [DATA_W-1:0]        mem [NUM_REGISTERS];
  logic [NUM_REGISTERS-1:0] vld;

  item_t             it;
  logic [DATA_W-1:0] rd_a;
  logic [DATA_W-1:0] rd_b;
  logic              ok_a;
  logic              ok_b;
  logic [ADDR_W-1:0] pc;
  logic              stopped;

  logic [RW-1:0]     idx_a;
  logic [RW-1:0]     idx_b;
  logic              in_a;
  logic              in_b;

  logic [DATA_W-1:0] b;
  logic [DATA_W-1:0] c;
  logic [DATA_W-1:0] ma;
  logic [DATA_W-1:0] mb;
  logic [DATA_W-1:0] dq;
  logic [DATA_W-1:0] dr;
  logic [DATA_W-1:0] q;
  logic [DATA_W-1:0] r;
  logic              div_busy;
  logic              div_done;

  logic              active;
  logic              div_op;
  logic              wv;
  logic              wv_eff;
  logic [DATA_W-1:0] wval;
  logic              pv;
  logic              derr;
  logic              jump;
  logic              do_exit;
  logic              dest_ok;
  logic [ADDR_W:0]   next_full;
  logic              leave;
  logic [ADDR_W-1:0] pc_next;
  logic              stopped_next;
  result_t           res;

  // read addresses come straight off the input beat
  always_comb begin
    idx_a = item.first_operand[RW-1:0];
    in_a  = $unsigned(item.first_operand) < DATA_W'(NUM_REGISTERS);
    if (item.command == OP_SYS) begin
      idx_b = item.dest[RW-1:0];
      in_b  = DATA_W'(item.dest) < DATA_W'(NUM_REGISTERS);
    end else begin
      idx_b = item.second_operand[RW-1:0];
      in_b  = $unsigned(item.second_operand) < DATA_W'(NUM_REGISTERS);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      it   <= item;
      rd_a <= mem[idx_a];
      rd_b <= mem[idx_b];
      ok_a <= in_a && vld[idx_a];
      ok_b <= in_b && vld[idx_b];
    end
    if (ctl.commit && active && wv_eff) begin
      mem[it.dest[RW-1:0]] <= wval;
    end
  end

  always_comb begin
    b = it.first_is_register ? (ok_a ? rd_a : '0) : it.first_operand;
    c = it.second_is_register ? (ok_b ? rd_b : '0) : it.second_operand;
    ma = b[DATA_W-1] ? (~b + DATA_W'(1)) : b;
    mb = c[DATA_W-1] ? (~c + DATA_W'(1)) : c;
    q  = (b[DATA_W-1] ^ c[DATA_W-1]) ? (~dq + DATA_W'(1)) : dq;
    r  = b[DATA_W-1] ? (~dr + DATA_W'(1)) : dr;
  end

  trm_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (ctl.start_div),
    .dividend  (ma),
    .divisor   (mb),
    .busy      (div_busy),
    .done      (div_done),
    .quotient  (dq),
    .remainder (dr)
  );

  always_comb begin
    active  = !stopped && !(pc > last_address);
    div_op  = (it.command == OP_DIV) || (it.command == OP_REM);
    wv      = 1'b0;
    wval    = '0;
    pv      = 1'b0;
    derr    = 1'b0;
    jump    = 1'b0;
    do_exit = 1'b0;
    case (it.command)
      OP_MOV: begin
        wv   = 1'b1;
        wval = b;
      end
      OP_ADD: begin
        wv   = 1'b1;
        wval = b + c;
      end
      OP_SUB: begin
        wv   = 1'b1;
        wval = b - c;
      end
      OP_MUL: begin
        wv   = 1'b1;
        wval = b * c;
      end
      OP_DIV, OP_REM: begin
        wv = 1'b1;
        if (c == '0) begin
          derr = 1'b1;
        end else begin
          wval = (it.command == OP_DIV) ? q : r;
        end
      end
      OP_JUMP: begin
        jump = 1'b1;
      end
      OP_JUMPN: begin
        jump = b[DATA_W-1];
      end
      OP_JUMPP: begin
        jump = !b[DATA_W-1] && (b != '0);
      end
      OP_JUMPZ: begin
        jump = (b == '0);
      end
      OP_SYS: begin
        if (b == SYS_READ) begin
          wv   = 1'b1;
          wval = it.read_value;
        end else if (b == SYS_PRINT) begin
          pv = 1'b1;
        end
      end
      OP_EXIT: begin
        do_exit = 1'b1;
      end
      default: begin
        wv = 1'b0;
      end
    endcase

    dest_ok   = DATA_W'(it.dest) < DATA_W'(NUM_REGISTERS);
    wv_eff    = wv && dest_ok;
    next_full = jump ? {1'b0, it.dest} : ({1'b0, pc} + (ADDR_W+1)'(1));
    leave     = (next_full > {1'b0, last_address}) ||
                (DATA_W'(next_full) >= DATA_W'(PROGRAM_DEPTH));

    res = '0;
    if (!active) begin
      // already stopped or counter beyond the program: nothing executes
      pc_next      = pc;
      stopped_next = 1'b1;
    end else begin
      if (do_exit) begin
        pc_next      = pc;
        stopped_next = 1'b1;
      end else begin
        pc_next      = next_full[ADDR_W-1:0];
        stopped_next = leave;
      end
      res.write_valid  = wv_eff;
      res.write_index  = wv_eff ? it.dest[WIDX_W-1:0] : '0;
      res.write_value  = wv_eff ? wval : '0;
      res.print_valid  = pv;
      res.print_value  = (pv && ok_b) ? rd_b : '0;
      res.divide_error = derr;
    end
    res.next_address = pc_next;
    res.halted       = stopped_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld          <= '0;
      pc           <= '0;
      stopped      <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (ctl.commit) begin
        pc           <= pc_next;
        stopped      <= stopped_next;
        result_valid <= 1'b1;
        if (active && wv_eff) begin
          vld[it.dest[RW-1:0]] <= 1'b1;
        end
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      result <= res;
    end
  end

  always_comb begin
    sts.div_needed = active && div_op && (c != '0);
    sts.div_done   = div_done;
    sts.div_busy   = div_busy;
    sts.out_free   = !result_valid || result_ready;
  end

endmodule

### src/toy_register_machine_execute.sv
// ---------------------------------------------------------------------------
// toy_register_machine_execute
// executes one pre-decoded instruction per beat on a 26 x 32-bit register
// file with a program counter; apb port holds the last program address
// ---------------------------------------------------------------------------
//  channel   dir   handshake             payload
//  item      in    item_valid/ready      trm_pkg::item_t
//  result    out   result_valid/ready    trm_pkg::result_t
//  apb       in    psel/penable/pready   last_address at byte address 0
//
//  most instructions: beat loaded on accept, result registered on commit from exec
//  div and rem with a nonzero divisor: after accept the beat passes start,
//  32 one-bit divider steps, done handoff and commit
//  a new beat is taken as soon as the previous one commits, even while
//  its result still waits on result_ready; commit waits for a free slot
//  synchronous reset clears registers, counter and halt state, no sweep
// ---------------------------------------------------------------------------
`include "toy_register_machine_execute_assert.svh"

module toy_register_machine_execute #(
  parameter int NUM_REGISTERS = 26,
  parameter int PROGRAM_DEPTH = 1024
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       item_valid,
  output logic                       item_ready,
  input  trm_pkg::item_t             item,
  output logic                       result_valid,
  input  logic                       result_ready,
  output trm_pkg::result_t           result,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [2:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import trm_pkg::*;

  ctl_t              ctl;
  sts_t              sts;
  logic [ADDR_W-1:0] last_address;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_address <= '0;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LAST_ADDRESS)) begin
      last_address <= pwdata[ADDR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LAST_ADDRESS) ? 32'(last_address) : '0;

  trm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_ready (item_ready),
    .sts        (sts),
    .ctl        (ctl)
  );

  trm_dp #(
    .NUM_REGISTERS (NUM_REGISTERS),
    .PROGRAM_DEPTH (PROGRAM_DEPTH)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .ctl          (ctl),
    .sts          (sts),
    .last_address (last_address),
    .result       (result),
    .result_valid (result_valid),
    .result_ready (result_ready)
  );

  // no beat is taken while the divider is still working
  `TRM_ASSERT_IMPL(a_ready_not_dividing, item_ready, !sts.div_busy)
  // an accepted beat closes the input until it commits
  `TRM_ASSERT_NEXT(a_accept_closes, item_valid && item_ready, !item_ready)
  // a commit always leaves a result waiting
  `TRM_ASSERT_NEXT(a_commit_fills, ctl.commit, result_valid)
  // a zero divisor writes zero and prints nothing
  `TRM_ASSERT_IMPL(a_div_error_zero, result_valid && result.divide_error,
                   result.write_value == '0 && !result.print_valid)

endmodule

### bench/toy_register_machine_execute_checker.sv
// ---------------------------------------------------------------------------
// toy_register_machine_execute_checker
// watches the item, result and apb channels, predicts every result beat
// from its own copy of the register file, counter and halt state, and
// compares each result beat field by field with the oldest prediction
// ---------------------------------------------------------------------------
module toy_register_machine_execute_checker
  import trm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        item_valid,
  input  logic        item_ready,
  input  item_t       item,
  input  logic        result_valid,
  input  logic        result_ready,
  input  result_t     result,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          mismatches,
  output int          outstanding
);

  localparam int REG_COUNT  = 26;
  localparam int ADDR_SPACE = 1024;
  localparam logic [2:0] LAST_ADDRESS_ADDR = {REG_LAST_ADDRESS, 2'b00};

  logic [DATA_W-1:0] regs [REG_COUNT];
  logic [ADDR_W-1:0] pc;
  logic              stopped;
  logic [ADDR_W-1:0] last_addr;

  result_t predicted_results [$];
  result_t predicted;
  result_t oldest;

  initial begin
    mismatches  = 0;
    outstanding = 0;
  end

  function automatic logic [DATA_W-1:0] reg_value(input logic [DATA_W-1:0] idx);
    return (idx < REG_COUNT) ? regs[idx[WIDX_W-1:0]] : '0;
  endfunction

  function automatic logic [DATA_W-1:0] operand(input logic is_reg,
                                                input logic [DATA_W-1:0] raw);
    return is_reg ? reg_value(raw) : raw;
  endfunction

  task automatic execute(input item_t it, output result_t r);
    logic [DATA_W-1:0] b, c, wval, pval, ma, mb, mq, mr;
    logic              wv, pv, derr, jmp;
    logic [ADDR_W:0]   next;
    r    = '0;
    b    = operand(it.first_is_register, it.first_operand);
    c    = operand(it.second_is_register, it.second_operand);
    wval = '0;
    pval = '0;
    wv   = 1'b0;
    pv   = 1'b0;
    derr = 1'b0;
    jmp  = 1'b0;
    // counter left behind by a lowered last address
    if (!stopped && pc > last_addr) stopped = 1'b1;
    if (stopped) begin
      r.next_address = pc;
      r.halted       = 1'b1;
    end else begin
      case (it.command)
        OP_MOV: begin
          wv = 1'b1; wval = b;
        end
        OP_ADD: begin
          wv = 1'b1; wval = b + c;
        end
        OP_SUB: begin
          wv = 1'b1; wval = b - c;
        end
        OP_MUL: begin
          wv = 1'b1; wval = b * c;
        end
        OP_DIV, OP_REM: begin
          wv = 1'b1;
          if (c == '0) begin
            derr = 1'b1;
          end else begin
            // divide magnitudes so that min over minus one cannot trap
            ma = b[DATA_W-1] ? -b : b;
            mb = c[DATA_W-1] ? -c : c;
            mq = ma / mb;
            mr = ma % mb;
            if (it.command == OP_DIV) wval = (b[DATA_W-1] ^ c[DATA_W-1]) ? -mq : mq;
            else wval = b[DATA_W-1] ? -mr : mr;
          end
        end
        OP_JUMP:  jmp = 1'b1;
        OP_JUMPN: jmp = b[DATA_W-1];
        OP_JUMPP: jmp = !b[DATA_W-1] && (b != '0);
        OP_JUMPZ: jmp = (b == '0);
        OP_SYS: begin
          if (b == SYS_READ) begin
            wv = 1'b1; wval = it.read_value;
          end else if (b == SYS_PRINT) begin
            pv = 1'b1; pval = reg_value(DATA_W'(it.dest));
          end
        end
        OP_EXIT: stopped = 1'b1;
        default: ;
      endcase
      if (wv) begin
        if (it.dest < REG_COUNT) begin
          regs[it.dest[WIDX_W-1:0]] = wval;
        end else begin
          wv   = 1'b0;
          wval = '0;
        end
      end
      if (!stopped) begin
        next = jmp ? {1'b0, it.dest} : {1'b0, pc} + 1'b1;
        if (next > last_addr || next >= ADDR_SPACE) stopped = 1'b1;
        pc = next[ADDR_W-1:0];
      end
      r.next_address = pc;
      r.halted       = stopped;
      r.write_valid  = wv;
      r.write_index  = wv ? it.dest[WIDX_W-1:0] : '0;
      r.write_value  = wval;
      r.print_valid  = pv;
      r.print_value  = pval;
      r.divide_error = derr;
    end
  endtask

  task automatic report(input string what);
    mismatches++;
    if (mismatches <= 10) $display("%t %s", $time, what);
  endtask

  task automatic compare(input string field, input logic [DATA_W-1:0] e,
                         input logic [DATA_W-1:0] a);
    if (a !== e) report($sformatf("%s mismatch: expected %0h got %0h", field, e, a));
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < REG_COUNT; k++) regs[k] = '0;
      pc        = '0;
      stopped   = 1'b0;
      last_addr = '0;
      predicted_results.delete();
    end else begin
      if (psel && penable && pwrite && pready && paddr == LAST_ADDRESS_ADDR)
        last_addr = pwdata[ADDR_W-1:0];
      if (item_valid && item_ready) begin
        execute(item, predicted);
        predicted_results.push_back(predicted);
      end
      if (result_valid && result_ready) begin
        if (predicted_results.size() == 0) begin
          report($sformatf("result beat with nothing expected: %p", result));
        end else begin
          oldest = predicted_results.pop_front();
          compare("next_address", DATA_W'(oldest.next_address), DATA_W'(result.next_address));
          compare("halted", DATA_W'(oldest.halted), DATA_W'(result.halted));
          compare("write_valid", DATA_W'(oldest.write_valid), DATA_W'(result.write_valid));
          compare("write_index", DATA_W'(oldest.write_index), DATA_W'(result.write_index));
          compare("write_value", oldest.write_value, result.write_value);
          compare("print_valid", DATA_W'(oldest.print_valid), DATA_W'(result.print_valid));
          compare("print_value", oldest.print_value, result.print_value);
          compare("divide_error", DATA_W'(oldest.divide_error),
                  DATA_W'(result.divide_error));
        end
      end
    end
    outstanding <= predicted_results.size();
  end

endmodule

### bench/toy_register_machine_execute_test.sv
// ---------------------------------------------------------------------------
// toy_register_machine_execute_test
// drives directed and random instruction beats and apb writes of the last
// program address into the execute block, with random gaps and back
// pressure; the checker beside the block predicts and compares
// ---------------------------------------------------------------------------
module toy_register_machine_execute_test;
  import trm_pkg::*;

  localparam int STALL_LIMIT = 3000;
  localparam logic [2:0] LAST_ADDRESS_ADDR = {REG_LAST_ADDRESS, 2'b00};

  // opcodes the block does not implement
  localparam logic [CMD_W-1:0] OP_LD   = 5'd1;
  localparam logic [CMD_W-1:0] OP_ST   = 5'd2;
  localparam logic [CMD_W-1:0] OP_DIVR = 5'd8;
  localparam logic [CMD_W-1:0] OP_PUSH = 5'd13;
  localparam logic [CMD_W-1:0] OP_POP  = 5'd14;
  localparam logic [CMD_W-1:0] OP_CALL = 5'd15;
  localparam logic [CMD_W-1:0] OP_RET  = 5'd17;
  localparam logic [CMD_W-1:0] OP_TOP  = '1;

  logic        clk = 1'b0;
  logic        rst;
  logic        item_valid;
  logic        item_ready;
  item_t       item_beat;
  logic        result_valid;
  logic        result_ready;
  result_t     result_beat;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  int mismatches;
  int outstanding;
  int quiet_cycles = 0;
  int limit_now    = 0;
  int pc_bound     = 0;   // upper bound on the program counter
  bit calm         = 1'b0;

  toy_register_machine_execute u_dut (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_beat),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  toy_register_machine_execute_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .item         (item_beat),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result_beat),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .pready       (pready),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    result_ready <= calm || ($urandom_range(99) >= 27);
  end

  always @(posedge clk) begin
    if (rst || (item_valid && item_ready) || (result_valid && result_ready) ||
        (psel && penable)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  function automatic item_t instr(input logic [CMD_W-1:0] cmd, input int dest,
                                  input int fr, input logic [DATA_W-1:0] f,
                                  input int sr, input logic [DATA_W-1:0] s,
                                  input logic [DATA_W-1:0] rv);
    item_t it;
    it.command            = cmd;
    it.dest               = ADDR_W'(dest);
    it.first_is_register  = 1'(fr);
    it.first_operand      = f;
    it.second_is_register = 1'(sr);
    it.second_operand     = s;
    it.read_value         = rv;
    return it;
  endfunction

  function automatic logic [DATA_W-1:0] corner_value();
    case ($urandom_range(5))
      0:       return 32'h0000_0000;
      1:       return 32'h0000_0001;
      2:       return 32'hffff_ffff;
      3:       return 32'h8000_0000;
      4:       return 32'h7fff_ffff;
      default: return 32'h0000_0002;
    endcase
  endfunction

  function automatic void pick_operand(output logic is_reg, output logic [DATA_W-1:0] v);
    is_reg = 1'($urandom_range(1));
    if (is_reg) begin
      case ($urandom_range(9))
        0:       v = $urandom;
        1:       v = $urandom_range(26, 31);
        default: v = $urandom_range(0, 25);
      endcase
    end else begin
      case ($urandom_range(3))
        0:       v = corner_value();
        1:       v = DATA_W'($urandom_range(0, 20)) - 32'd10;
        default: v = $urandom;
      endcase
    end
  endfunction

  function automatic item_t random_item();
    item_t             it;
    logic              r1, r2;
    logic [DATA_W-1:0] v1, v2;
    int                pick;
    pick_operand(r1, v1);
    pick_operand(r2, v2);
    it = instr(OP_MOV, ($urandom_range(99) < 85) ? $urandom_range(0, 25)
                                                 : $urandom_range(0, 1023),
               int'(r1), v1, int'(r2), v2, $urandom);
    pick = $urandom_range(99);
    if (pc_bound >= limit_now) begin
      // pull the counter back before it runs off the program
      it.command = OP_JUMP;
      it.dest    = ADDR_W'($urandom_range(0, limit_now / 4));
    end else if (pick < 45) begin
      case ($urandom_range(5))
        0:       it.command = OP_MOV;
        1:       it.command = OP_ADD;
        2:       it.command = OP_SUB;
        3:       it.command = OP_MUL;
        4:       it.command = OP_DIV;
        default: it.command = OP_REM;
      endcase
    end else if (pick < 60) begin
      case ($urandom_range(3))
        0:       it.command = OP_JUMP;
        1:       it.command = OP_JUMPN;
        2:       it.command = OP_JUMPP;
        default: it.command = OP_JUMPZ;
      endcase
      it.dest = ADDR_W'($urandom_range(0, limit_now));
    end else if (pick < 78) begin
      it.command = OP_SYS;
      case ($urandom_range(9))
        0, 1, 2, 3: begin
          it.first_is_register = 1'b0; it.first_operand = SYS_READ;
        end
        4, 5, 6: begin
          it.first_is_register = 1'b0; it.first_operand = SYS_PRINT;
        end
        default: ;
      endcase
    end else if (pick < 88) begin
      case ($urandom_range(7))
        0:       it.command = OP_LD;
        1:       it.command = OP_ST;
        2:       it.command = OP_DIVR;
        3:       it.command = OP_PUSH;
        4:       it.command = OP_POP;
        5:       it.command = OP_CALL;
        6:       it.command = OP_RET;
        default: it.command = CMD_W'($urandom_range(int'(OP_EXIT) + 1, int'(OP_TOP)));
      endcase
    end else begin
      it.command = $urandom_range(1) ? OP_DIV : OP_REM;
      if ($urandom_range(1)) begin
        it.first_is_register  = 1'b0;
        it.first_operand      = 32'h8000_0000;
        it.second_is_register = 1'b0;
        it.second_operand     = 32'hffff_ffff;
      end else begin
        it.second_is_register = 1'b0;
        it.second_operand     = '0;
      end
    end
    return it;
  endfunction

  task automatic issue(input item_t it);
    if (!calm) begin
      while ($urandom_range(99) < 27) begin
        item_valid <= 1'b0;
        @(posedge clk);
      end
    end
    item_beat  <= it;
    item_valid <= 1'b1;
    do @(posedge clk); while (!item_ready);
    case (it.command)
      OP_JUMP: pc_bound = int'(it.dest);
      OP_JUMPN, OP_JUMPP, OP_JUMPZ: begin
        if (int'(it.dest) > pc_bound + 1) pc_bound = int'(it.dest);
        else pc_bound++;
      end
      default: pc_bound++;
    endcase
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_last_address(input int value);
    wait_idle();
    apb_write(LAST_ADDRESS_ADDR, value);
    limit_now = value;
  endtask

  initial begin
    int mode;
    int span;
    rst          <= 1'b1;
    item_valid   <= 1'b0;
    item_beat    <= '0;
    result_ready <= 1'b0;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    set_last_address(0);
    set_last_address(63);

    // directed: corners of the arithmetic, services and branches
    issue(instr(OP_MOV, 0, 0, 32'h7fff_ffff, 0, 0, 0));
    issue(instr(OP_MOV, 1, 0, 32'h8000_0000, 1, 3, 0));
    issue(instr(OP_SUB, 2, 0, 0, 0, 1, 0));
    issue(instr(OP_ADD, 3, 1, 0, 0, 1, 0));
    issue(instr(OP_SUB, 4, 1, 1, 0, 1, 0));
    issue(instr(OP_MUL, 5, 1, 0, 1, 0, 0));
    issue(instr(OP_DIV, 7, 1, 1, 1, 2, 0));
    issue(instr(OP_REM, 8, 1, 1, 1, 2, 0));
    issue(instr(OP_DIV, 9, 0, -7, 0, 2, 0));
    issue(instr(OP_REM, 10, 0, -7, 0, 2, 0));
    issue(instr(OP_DIV, 12, 0, 5, 0, 0, 0));
    issue(instr(OP_REM, 13, 1, 0, 1, 25, 0));
    issue(instr(OP_ADD, 14, 1, -5, 0, 9, 0));
    issue(instr(OP_ADD, 15, 1, 26, 1, 14, 0));
    issue(instr(OP_MOV, 1023, 0, 1, 0, 0, 0));
    issue(instr(OP_SYS, 16, 0, SYS_READ, 0, 0, 32'h8000_0001));
    issue(instr(OP_SYS, 16, 0, SYS_PRINT, 0, 0, 0));
    issue(instr(OP_SYS, 700, 0, SYS_PRINT, 0, 0, 0));
    issue(instr(OP_SYS, 17, 0, 3, 0, 0, 32'h1234_5678));
    issue(instr(OP_LD, 18, 0, 1, 0, 1, 0));
    issue(instr(OP_TOP, 19, 1, 2, 1, 3, 0));
    issue(instr(OP_JUMPN, 30, 1, 1, 0, 0, 0));
    issue(instr(OP_JUMPP, 50, 1, 2, 0, 0, 0));
    issue(instr(OP_JUMPP, 45, 0, 5, 0, 0, 0));
    issue(instr(OP_JUMPZ, 0, 0, 0, 0, 0, 0));
    issue(instr(OP_JUMP, 20, 0, 0, 0, 0, 0));

    set_last_address($urandom_range(200, 700));
    for (int i = 0; i < 250; i++) issue(random_item());

    set_last_address(1023);
    for (int i = 0; i < 275; i++) begin
      calm = (i >= 100 && i < 220);
      issue(random_item());
    end
    calm = 1'b0;

    // the machine halts only once, so pick one way out per run
    mode = $urandom_range(3);
    case (mode)
      0: issue(instr(OP_EXIT, $urandom_range(0, 1023), 0, $urandom, 0, $urandom, 0));
      1: begin
        issue(instr(OP_JUMP, 5, 0, 0, 0, 0, 0));
        set_last_address(0);
      end
      2: begin
        issue(instr(OP_JUMP, 1023, 0, 0, 0, 0, 0));
        issue(instr(OP_MOV, 0, 0, 0, 0, 0, 0));
      end
      default: begin
        issue(instr(OP_JUMP, 5, 0, 0, 0, 0, 0));
        span = $urandom_range(100, 900);
        set_last_address(span);
        issue(instr(OP_JUMPZ, $urandom_range(span + 1, 1023), 0, 0, 0, 0, 0));
      end
    endcase
    for (int i = 0; i < 6; i++) issue(random_item());

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) $display("CHECK OK");
    else $display("CHECK FAILED");
    $finish;
  end

endmodule
